// ----- rtl/core/kmp_first_match_finder_unit_defines.svh -----
// Assertion macros for the first-match finder RTL.
`ifndef KMP_FIRST_MATCH_FINDER_UNIT_DEFINES_SVH
`define KMP_FIRST_MATCH_FINDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define KMP_FMF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequence holds in the same cycle as its trigger.
`define KMP_FMF_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

`else

`define KMP_FMF_ASSERT(label, cond, msg)
`define KMP_FMF_ASSERT_IMPL(label, trig, cons, msg)

`endif

`endif

// ----- rtl/core/kmp_fmf_pkg.sv -----
// Shared constants, types and codes of the first-match finder.
package kmp_fmf_pkg;

  // Pattern capacity and text position limit.
  localparam int PAT_MAX   = 255;
  localparam int TEXT_MAX  = 65535;

  // Derived widths.
  localparam int CNT_W     = $clog2(PAT_MAX + 1);
  localparam int PTR_W     = $clog2(PAT_MAX + 2);
  localparam int RAM_DEPTH = PAT_MAX + 1;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int TP_W      = $clog2(TEXT_MAX + 1);

  // Fixed field widths.
  localparam int SYM_W     = 8;
  localparam int CMD_W     = 2;
  localparam int POS_W     = 16;

  // Front queue depth.
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  // Configuration port.
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam logic REG_IMPROVED = 1'b0;

  // Input command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

  // Classified work for the back end.
  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_APPEND,
    KIND_TEXT
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } op_t;

  // Head of the front queue as seen by the back end.
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_link_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD_CMP,
    ST_BUILD_FIN,
    ST_TEXT_CMP
  } state_t;

endpackage

// ----- rtl/core/kmp_fmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kmp_fmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/core/kmp_fmf_front.sv -----
// Front end: accepts input beats, classifies commands and queues the work.
module kmp_fmf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [kmp_fmf_pkg::CMD_W-1:0] in_command,
  input  logic [kmp_fmf_pkg::SYM_W-1:0] in_symbol,
  input  logic                          in_last_text,
  output kmp_fmf_pkg::q_link_t          q_o,
  input  logic                          q_pop_i
);
  import kmp_fmf_pkg::*;

  op_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            accept;
  logic            known;
  logic            enq;
  logic            deq;
  op_t             op_in;

  // Classify the command; the unused code is dropped here.
  always_comb begin
    known       = 1'b1;
    op_in.kind  = KIND_TEXT;
    unique case (in_command)
      CMD_CLEAR:  op_in.kind = KIND_CLEAR;
      CMD_APPEND: op_in.kind = KIND_APPEND;
      CMD_TEXT:   op_in.kind = KIND_TEXT;
      default:    known = 1'b0;
    endcase
    op_in.symbol = in_symbol;
    op_in.last   = in_last_text;
  end

  assign full   = (cnt_r == Q_CW'(Q_DEPTH));
  assign accept = push && !full;
  assign enq    = accept && known;
  assign deq    = q_pop_i && (cnt_r != '0);

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= op_in;
    end
  end

  assign q_o.valid = (cnt_r != '0);
  assign q_o.op    = mem_r[rd_ptr_r];

endmodule

// ----- rtl/core/kmp_fmf_back.sv -----
// Back end: builds the failure table and scans text bytes one beat at a time.
`include "kmp_first_match_finder_unit_defines.svh"

module kmp_fmf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmp_fmf_pkg::q_link_t          q_i,
  output logic                          q_pop_o,
  input  logic                          use_improved_i,
  input  logic                          out_pop_i,
  output logic                          out_valid_o,
  output logic                          out_found_o,
  output logic [kmp_fmf_pkg::POS_W-1:0] out_position_o
);
  import kmp_fmf_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   bp_r, bp_nxt;
  logic [PTR_W-1:0]   mp_r, mp_nxt;
  logic [TP_W-1:0]    tp_r, tp_nxt;
  logic               reported_r, reported_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [SYM_W-1:0]   prev_sym_r, prev_sym_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               last_r, last_nxt;
  logic [PTR_W-1:0]   j_r, j_nxt;
  logic               out_found_r, out_found_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;

  logic               out_free;
  logic               out_load;
  logic [PTR_W-1:0]   jf;
  logic [TP_W:0]      pos_wide;
  logic [POS_W-1:0]   pos_sat;
  logic [CNT_W-1:0]   m_idx;

  logic               we;
  logic [RAM_AW-1:0]  waddr;
  logic [SYM_W-1:0]   wdata_p;
  logic [CNT_W-1:0]   wdata_f;
  logic [RAM_AW-1:0]  raddr;
  logic [SYM_W-1:0]   p_rd;
  logic [CNT_W-1:0]   f_rd;

  // Pattern bytes and failure links, both read at the same pointer.
  kmp_fmf_ram #(.WIDTH(SYM_W), .DEPTH(RAM_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_p),
    .raddr (raddr),
    .rdata (p_rd)
  );

  kmp_fmf_ram #(.WIDTH(CNT_W), .DEPTH(RAM_DEPTH)) u_fail_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_f),
    .raddr (raddr),
    .rdata (f_rd)
  );

  assign out_free = !out_valid_r || out_pop_i;
  assign m_idx    = count_r + 1'b1;

  // Start of the match in the text, clamped to the reported range.
  always_comb begin
    pos_wide = {1'b0, tp_r} - (TP_W + 1)'(count_r) + 1'b1;
    if (tp_r < TP_W'(count_r)) begin
      pos_sat = POS_W'(1);
    end else if (pos_wide > (TP_W + 1)'({POS_W{1'b1}})) begin
      pos_sat = {POS_W{1'b1}};
    end else begin
      pos_sat = POS_W'(pos_wide);
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    bp_nxt        = bp_r;
    mp_nxt        = mp_r;
    tp_nxt        = tp_r;
    reported_nxt  = reported_r;
    prev_sym_nxt  = prev_sym_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    out_load      = 1'b0;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    q_pop_o       = 1'b0;
    we            = 1'b0;
    waddr         = m_idx[RAM_AW-1:0];
    wdata_p       = sym_r;
    wdata_f       = j_r[CNT_W-1:0];
    raddr         = j_r[RAM_AW-1:0];
    jf            = j_r + 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (q_i.valid && out_free) begin
          q_pop_o = 1'b1;
          unique case (q_i.op.kind)
            KIND_CLEAR: begin
              count_nxt    = '0;
              bp_nxt       = '0;
              mp_nxt       = PTR_W'(1);
              tp_nxt       = '0;
              reported_nxt = 1'b0;
            end
            KIND_APPEND: begin
              mp_nxt       = PTR_W'(1);
              tp_nxt       = '0;
              reported_nxt = 1'b0;
              if (count_r != CNT_W'(PAT_MAX)) begin
                sym_nxt = q_i.op.symbol;
                if (count_r == '0) begin
                  // First byte: its link is always zero.
                  we           = 1'b1;
                  waddr        = RAM_AW'(1);
                  wdata_p      = q_i.op.symbol;
                  wdata_f      = '0;
                  count_nxt    = CNT_W'(1);
                  bp_nxt       = '0;
                  prev_sym_nxt = q_i.op.symbol;
                end else if (bp_r == '0) begin
                  j_nxt     = PTR_W'(1);
                  raddr     = RAM_AW'(1);
                  state_nxt = ST_BUILD_FIN;
                end else begin
                  j_nxt     = PTR_W'(bp_r);
                  raddr     = bp_r[RAM_AW-1:0];
                  state_nxt = ST_BUILD_CMP;
                end
              end
            end
            KIND_TEXT: begin
              if (reported_r) begin
                if (q_i.op.last) begin
                  mp_nxt       = PTR_W'(1);
                  tp_nxt       = '0;
                  reported_nxt = 1'b0;
                end
              end else begin
                tp_nxt = (tp_r != TP_W'(TEXT_MAX)) ? tp_r + 1'b1 : tp_r;
                if (count_r == '0) begin
                  // Empty pattern matches at the first byte.
                  out_load      = 1'b1;
                  out_found_nxt = 1'b1;
                  out_pos_nxt   = POS_W'(1);
                  reported_nxt  = 1'b1;
                  if (q_i.op.last) begin
                    mp_nxt       = PTR_W'(1);
                    tp_nxt       = '0;
                    reported_nxt = 1'b0;
                  end
                end else begin
                  sym_nxt   = q_i.op.symbol;
                  last_nxt  = q_i.op.last;
                  j_nxt     = mp_r;
                  raddr     = mp_r[RAM_AW-1:0];
                  state_nxt = ST_TEXT_CMP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_BUILD_CMP: begin
        // Walk the links until the previous byte extends a border.
        if (prev_sym_r == p_rd) begin
          j_nxt     = j_r + 1'b1;
          raddr     = jf[RAM_AW-1:0];
          state_nxt = ST_BUILD_FIN;
        end else if (f_rd == '0) begin
          j_nxt     = PTR_W'(1);
          raddr     = RAM_AW'(1);
          state_nxt = ST_BUILD_FIN;
        end else begin
          j_nxt = PTR_W'(f_rd);
          raddr = f_rd[RAM_AW-1:0];
        end
      end

      ST_BUILD_FIN: begin
        // Store the new byte and its link, skipping equal characters if asked.
        we      = 1'b1;
        waddr   = m_idx[RAM_AW-1:0];
        wdata_p = sym_r;
        if (use_improved_i && (sym_r == p_rd)) begin
          wdata_f = f_rd;
        end else begin
          wdata_f = j_r[CNT_W-1:0];
        end
        count_nxt    = m_idx;
        bp_nxt       = j_r[CNT_W-1:0];
        prev_sym_nxt = sym_r;
        state_nxt    = ST_IDLE;
      end

      ST_TEXT_CMP: begin
        if ((sym_r == p_rd) || (f_rd == '0)) begin
          jf        = (sym_r == p_rd) ? j_r + 1'b1 : PTR_W'(1);
          mp_nxt    = jf;
          state_nxt = ST_IDLE;
          if (jf > PTR_W'(count_r)) begin
            out_load      = 1'b1;
            out_found_nxt = 1'b1;
            out_pos_nxt   = pos_sat;
            reported_nxt  = 1'b1;
          end else if (last_r) begin
            out_load      = 1'b1;
            out_found_nxt = 1'b0;
            out_pos_nxt   = '0;
          end
          if (last_r) begin
            mp_nxt       = PTR_W'(1);
            tp_nxt       = '0;
            reported_nxt = 1'b0;
          end
        end else begin
          j_nxt = PTR_W'(f_rd);
          raddr = f_rd[RAM_AW-1:0];
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result register: loaded by the sequencer, drained by the receiver.
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      bp_r        <= '0;
      mp_r        <= PTR_W'(1);
      tp_r        <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bp_r        <= bp_nxt;
      mp_r        <= mp_nxt;
      tp_r        <= tp_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prev_sym_r  <= prev_sym_nxt;
    sym_r       <= sym_nxt;
    last_r      <= last_nxt;
    j_r         <= j_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_valid_o    = out_valid_r;
  assign out_found_o    = out_found_r;
  assign out_position_o = out_pos_r;

  // Consistency checks on the sequencer.
  `KMP_FMF_ASSERT_IMPL(a_load_free, out_load, (!out_valid_r || out_pop_i), "result overwritten")
  `KMP_FMF_ASSERT(a_mp_range, (mp_r != '0 && mp_r <= PTR_W'(count_r) + 1'b1), "match pointer range")
  `KMP_FMF_ASSERT(a_bp_range, ((count_r == '0) ? (bp_r == '0) : (bp_r < count_r)), "build pointer")
  `KMP_FMF_ASSERT_IMPL(a_text_j, (state_r == ST_TEXT_CMP), (j_r != '0 && j_r <= PTR_W'(count_r)), "scan pointer")
  `KMP_FMF_ASSERT_IMPL(a_build_room, (state_r == ST_BUILD_CMP || state_r == ST_BUILD_FIN), (count_r != '0 && count_r != CNT_W'(PAT_MAX)), "append beyond capacity")

endmodule

// ----- rtl/core/kmp_first_match_finder_unit.sv -----
// Top level of the first-match string finder: queue ports and register port.
//
// Input channel: push/full with in_command, in_symbol and in_last_text. Commands
// clear the pattern, append a pattern byte, or carry a text byte. Beats enter a
// four-entry queue and are carried out one at a time by the back end.
// Result channel: empty/pop with out_found and out_position; one result register.
// Register 0 (use_improved_table) at byte address 0 selects the improved table.
// Write it only while the block is idle; it takes effect on later appends.
// Steps: a clear is done in the idle state; an append writes the first byte from idle,
// goes straight to the finish state when the build pointer is zero, and otherwise
// walks the failure links in the compare state before the finish state; a text byte
// walks the links in the text compare state, and is done in idle once the match is
// reported or with an empty pattern. The single read port of the pattern memories
// sets these steps. Each beat is finished before the back end takes the next one.
// A result is loaded into the result register when its text beat finishes.
// Reset clears the pattern, the scan state, the queue and the register.
// While the receiver stalls a waiting result, the back end takes no further beat;
// full rises once the queue fills.
module kmp_first_match_finder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [kmp_fmf_pkg::CMD_W-1:0]  in_command,
  input  logic [kmp_fmf_pkg::SYM_W-1:0]  in_symbol,
  input  logic                           in_last_text,
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_found,
  output logic [kmp_fmf_pkg::POS_W-1:0]  out_position,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kmp_fmf_pkg::CFG_AW-1:0] paddr,
  input  logic [kmp_fmf_pkg::CFG_DW-1:0] pwdata,
  output logic [kmp_fmf_pkg::CFG_DW-1:0] prdata,
  output logic                           pready
);
  import kmp_fmf_pkg::*;

  logic    use_improved_r, use_improved_nxt;
  logic    cfg_wr;
  logic    q_pop;
  logic    out_valid;
  q_link_t q_link;

  // Register port: no wait states, word index taken from the address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    use_improved_nxt = use_improved_r;
    if (cfg_wr && (paddr[2] == REG_IMPROVED)) begin
      use_improved_nxt = pwdata[0];
    end
    prdata = '0;
    if (paddr[2] == REG_IMPROVED) begin
      prdata[0] = use_improved_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_improved_r <= 1'b0;
    end else begin
      use_improved_r <= use_improved_nxt;
    end
  end

  kmp_fmf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_command   (in_command),
    .in_symbol    (in_symbol),
    .in_last_text (in_last_text),
    .q_o          (q_link),
    .q_pop_i      (q_pop)
  );

  kmp_fmf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_i            (q_link),
    .q_pop_o        (q_pop),
    .use_improved_i (use_improved_r),
    .out_pop_i      (pop),
    .out_valid_o    (out_valid),
    .out_found_o    (out_found),
    .out_position_o (out_position)
  );

  assign empty = !out_valid;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the first-match string finder: directed table, random sessions, long text.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kmp_fmf_pkg::*;

  // The fourth command code, which the block must ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_AW-1:0] IMPROVED_ADDR = CFG_AW'(4 * int'(REG_IMPROVED));
  localparam int RANDOM_BEATS   = 1100;
  localparam int SETTLE_CYCLES  = 1200;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_FILL      = 40;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } hit_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             typed;
    logic             has_hit;
    hit_t             hit;
  } dir_row_t;

  // Directed beats; typed rows carry their own expectation, the rest use the predictor.
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_TEXT,   8'h78, 1'b0, 1'b1, 1'b1, '{1'b1, 16'd1}},
    '{CMD_TEXT,   8'h79, 1'b1, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'h00, 1'b0, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'hFF, 1'b1, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h00, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'hFF, 1'b1, 1'b1, 1'b1, '{1'b1, 16'd2}},
    '{CMD_TEXT,   8'h00, 1'b1, 1'b1, 1'b1, '{1'b0, 16'd0}},
    '{CMD_CLEAR,  8'h00, 1'b0, 1'b1, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'h61, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'h62, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'h61, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'h62, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'h63, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h61, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h62, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h61, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h62, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h61, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h62, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h63, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h61, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_APPEND, 8'h61, 1'b0, 1'b0, 1'b0, '{1'b0, 16'd0}},
    '{CMD_TEXT,   8'h78, 1'b1, 1'b0, 1'b0, '{1'b0, 16'd0}}
  };

  // Block ports; the inputs are all known from time zero.
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              push         = 1'b0;
  logic              full;
  logic [CMD_W-1:0]  in_command   = CMD_CLEAR;
  logic [SYM_W-1:0]  in_symbol    = '0;
  logic              in_last_text = 1'b0;
  logic              empty;
  logic              pop          = 1'b0;
  logic              out_found;
  logic [POS_W-1:0]  out_position;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [CFG_AW-1:0] paddr        = '0;
  logic [CFG_DW-1:0] pwdata       = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Predictor state: pattern, failure links and scan progress.
  logic [SYM_W-1:0] pat_bytes [1:PAT_MAX];
  logic [CNT_W-1:0] fail_link [1:PAT_MAX];
  logic [CNT_W-1:0] pat_len      = '0;
  logic [CNT_W-1:0] build_idx    = '0;
  logic [PTR_W-1:0] scan_idx     = PTR_W'(1);
  logic [TP_W-1:0]  text_count   = '0;
  logic             hit_seen     = 1'b0;
  logic             improved_cfg = 1'b0;

  hit_t        pending_hits [$];
  int          fail_count   = 0;
  int unsigned beats_sent   = 0;
  int unsigned pop_hold     = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;

  kmp_first_match_finder_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_command   (in_command),
    .in_symbol    (in_symbol),
    .in_last_text (in_last_text),
    .empty        (empty),
    .pop          (pop),
    .out_found    (out_found),
    .out_position (out_position),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void restart_scan();
    scan_idx   = PTR_W'(1);
    text_count = '0;
    hit_seen   = 1'b0;
  endfunction

  // Extend the pattern by one byte and compute its failure link.
  function automatic void add_pattern_byte(logic [SYM_W-1:0] c);
    logic [PTR_W-1:0] m;
    logic [PTR_W-1:0] i;
    logic [PTR_W-1:0] j;
    if (pat_len >= PAT_MAX) return;
    m = {1'b0, pat_len} + PTR_W'(1);
    pat_bytes[m] = c;
    pat_len = m[CNT_W-1:0];
    if (m == PTR_W'(1)) begin
      fail_link[1] = '0;
      build_idx    = '0;
      return;
    end
    i = m - PTR_W'(1);
    j = {1'b0, build_idx};
    while (j != 0 && pat_bytes[i] != pat_bytes[j]) j = {1'b0, fail_link[j]};
    j = j + PTR_W'(1);
    if (j > PAT_MAX) j = PTR_W'(PAT_MAX);
    // The improved form skips a link whose character equals this one.
    if (improved_cfg && pat_bytes[m] == pat_bytes[j]) fail_link[m] = fail_link[j];
    else fail_link[m] = j[CNT_W-1:0];
    build_idx = j[CNT_W-1:0];
  endfunction

  // Advance the predictor by one accepted beat; returns 1 when a result is due.
  function automatic bit predict_hit(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                                     input logic last, output hit_t hit);
    logic [PTR_W-1:0] j;
    logic [16:0]      start;
    bit               got;
    got = 1'b0;
    hit = '0;
    case (cmd)
      CMD_CLEAR: begin
        pat_len   = '0;
        build_idx = '0;
        restart_scan();
      end
      CMD_APPEND: begin
        add_pattern_byte(sym);
        restart_scan();
      end
      CMD_TEXT: begin
        if (!hit_seen) begin
          j = scan_idx;
          if (text_count < TEXT_MAX) text_count = text_count + 1'b1;
          if (pat_len == 0) begin
            hit      = '{1'b1, POS_W'(1)};
            hit_seen = 1'b1;
            got      = 1'b1;
          end else begin
            while (j != 0 && j <= pat_len && sym != pat_bytes[j]) j = {1'b0, fail_link[j]};
            j = j + PTR_W'(1);
            if (j > pat_len) begin
              if ({1'b0, text_count} >= {9'b0, pat_len})
                start = {1'b0, text_count} - {9'b0, pat_len} + 17'd1;
              else
                start = 17'd1;
              if (start > 17'hFFFF) start = 17'hFFFF;
              hit      = '{1'b1, start[POS_W-1:0]};
              hit_seen = 1'b1;
              got      = 1'b1;
            end
            scan_idx = j;
          end
          if (last && !got) begin
            hit = '0;
            got = 1'b1;
          end
        end
        if (last) restart_scan();
      end
      default: ;
    endcase
    return got;
  endfunction

  // Offer one beat after a random gap and wait until it is taken.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic last, output bit has, output hit_t hit);
    int unsigned idle_n;
    idle_n = gap_len();
    if (idle_n != 0) begin
      push <= 1'b0;
      repeat (idle_n) @(posedge clk);
    end
    push         <= 1'b1;
    in_command   <= cmd;
    in_symbol    <= sym;
    in_last_text <= last;
    do @(posedge clk); while (full);
    has = predict_hit(cmd, sym, last, hit);
    if (cmd != CMD_UNUSED) beats_sent++;
  endtask

  task automatic send_predicted(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym, logic last);
    hit_t hit;
    bit   has;
    send_beat(cmd, sym, last, has, hit);
    if (has) pending_hits.push_back(hit);
  endtask

  // Let every expected result arrive, then allow the back end to finish pattern work.
  task automatic settle();
    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_improved_reg(logic [CFG_DW-1:0] want);
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b0, IMPROVED_ADDR, '0, rd);
    if (rd !== want) begin
      $error("field use_improved_table: expected %0h, actual %0h", want, rd);
      fail_count++;
    end
  endtask

  task automatic set_improved(logic val);
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b1, IMPROVED_ADDR, CFG_DW'(val), rd);
    improved_cfg = val;
    check_improved_reg(CFG_DW'(val));
  endtask

  // One random session: a fresh pattern over a small alphabet, then a few texts.
  task automatic run_session(bit force_long);
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] pat_copy [$];
    int unsigned      alpha, plen, split, ntexts, tlen, at, r, k, i;
    bit               embed, fin;
    calm = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 4) == 0) begin
      settle();
      set_improved(!improved_cfg);
    end
    base  = SYM_W'($urandom_range(0, 255));
    alpha = $urandom_range(1, 4);
    r     = $urandom_range(0, 99);
    if (force_long) plen = $urandom_range(250, 262);
    else if (r < 10) plen = 0;
    else plen = $urandom_range(1, 7);
    // Now and then the table mode flips partway through loading.
    split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, plen) : plen + 1;
    send_predicted(CMD_CLEAR, SYM_W'($urandom), 1'($urandom));
    for (k = 0; k < plen; k++) begin
      if (k == split) begin
        settle();
        set_improved(!improved_cfg);
      end
      sym = base + SYM_W'($urandom_range(0, alpha - 1));
      if (k < PAT_MAX) pat_copy.push_back(sym);
      send_predicted(CMD_APPEND, sym, 1'($urandom));
    end
    ntexts = (plen > 200) ? 1 : $urandom_range(1, 4);
    repeat (ntexts) begin
      tlen  = (plen > 200) ? plen + $urandom_range(0, 20) : $urandom_range(1, 24);
      embed = $urandom_range(0, 1) && pat_copy.size() <= tlen;
      at    = embed ? $urandom_range(0, tlen - pat_copy.size()) : 0;
      fin   = ($urandom_range(0, 9) != 0);
      for (i = 0; i < tlen; i++) begin
        // Rare noise: ignored commands, a pattern change or a clear in mid-text.
        r = $urandom_range(0, 199);
        if (r == 0) send_predicted(CMD_UNUSED, SYM_W'($urandom), 1'($urandom));
        else if (r == 1) send_predicted(CMD_APPEND, base, 1'b0);
        else if (r == 2) send_predicted(CMD_CLEAR, base, 1'b1);
        if (embed && i >= at && i < at + pat_copy.size()) sym = pat_copy[i - at];
        else sym = base + SYM_W'($urandom_range(0, alpha - 1));
        send_predicted(CMD_TEXT, sym, fin && (i == tlen - 1));
      end
    end
  endtask

  // Result side: random stalls on pop, every accepted beat checked against the oldest expectation.
  always @(posedge clk) begin : result_side
    hit_t want;
    if (rst_n && pop && !empty) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result: found=%0b position=%0d", out_found, out_position);
        fail_count++;
      end else begin
        want = pending_hits.pop_front();
        if (out_found !== want.found) begin
          $error("field found: expected %0b, actual %0b", want.found, out_found);
          fail_count++;
        end
        if (out_position !== want.position) begin
          $error("field position: expected %0d, actual %0d", want.position, out_position);
          fail_count++;
        end
      end
      pop_hold = gap_len();
    end
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: ends the run after too long without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    hit_t        hit;
    bit          has;
    int unsigned n, first_beat;
    bit          first;
    // Reset, then check and write the register while idle.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_improved_reg('0);
    set_improved(1'b0);

    // Directed table.
    for (n = 0; n < DIR_ROWS; n++) begin
      row = DIRECTED[n];
      send_beat(row.cmd, row.sym, row.last, has, hit);
      if (row.typed) begin
        has = row.has_hit;
        hit = row.hit;
      end
      if (has) pending_hits.push_back(hit);
    end

    // Random sessions, the first one with a pattern near or past capacity.
    settle();
    set_improved(1'b1);
    first_beat = beats_sent;
    first      = 1'b1;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      run_session(first);
      first = 1'b0;
    end

    // One long text, sent back to back, that matches only near its end.
    settle();
    calm = 1'b1;
    send_predicted(CMD_CLEAR, 8'h00, 1'b0);
    send_predicted(CMD_APPEND, 8'h5A, 1'b0);
    send_predicted(CMD_APPEND, 8'hA5, 1'b0);
    repeat (LONG_FILL) send_predicted(CMD_TEXT, 8'h00, 1'b0);
    send_predicted(CMD_TEXT, 8'h5A, 1'b0);
    send_predicted(CMD_TEXT, 8'hA5, 1'b0);
    send_predicted(CMD_TEXT, 8'h11, 1'b1);

    // Drain and report.
    settle();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/kmp_fmf_pkg.sv
rtl/core/kmp_fmf_ram.sv
rtl/core/kmp_fmf_front.sv
rtl/core/kmp_fmf_back.sv
rtl/core/kmp_first_match_finder_unit.sv
test/tb_top.sv
